@@ rtl/pcrf_pkg.sv @@
// Package with register numbers, item codes, constants and helpers for the pulse channel core.
package pcrf_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Sound register numbers.
  localparam logic [4:0] REG_CH1_DUTY   = 5'd1;
  localparam logic [4:0] REG_CH1_PER_LO = 5'd3;
  localparam logic [4:0] REG_CH1_PER_HI = 5'd4;
  localparam logic [4:0] REG_CH2_DUTY   = 5'd5;
  localparam logic [4:0] REG_CH2_PER_LO = 5'd7;
  localparam logic [4:0] REG_CH2_PER_HI = 5'd8;
  localparam logic [4:0] REG_MASTER_VOL = 5'd18;
  localparam logic [4:0] REG_PANNING    = 5'd19;
  localparam logic [4:0] REG_AUDIO_CTRL = 5'd20;
  localparam logic [4:0] REG_WAVE       = 5'd21;
  localparam int unsigned REG_COUNT     = 21;

  // Read-back masks and fixed values.
  localparam logic [7:0] READ_MASK_DUTY = 8'b1100_0000;
  localparam logic [7:0] READ_MASK_CTRL = 8'b0100_0000;
  localparam logic [7:0] LENGTH_FIELD   = 8'b0011_1111;
  localparam logic [7:0] TRIGGER_BIT    = 8'h80;
  localparam logic [7:0] READ_UNMAPPED  = 8'hFF;

  // Reset values of the three audio control registers.
  localparam logic [7:0] RESET_MASTER_VOL = 8'h77;
  localparam logic [7:0] RESET_PANNING    = 8'hF3;
  localparam logic [7:0] RESET_AUDIO_CTRL = 8'hF1;

  // Channel timing constants.
  localparam int unsigned WAVE_BYTES_DEFAULT = 16;
  localparam logic [6:0]  LENGTH_MAX         = 7'd64;
  localparam logic [6:0]  DECIMATION         = 7'd95;
  localparam logic [11:0] PERIOD_BASE        = 12'd2048;
  localparam int unsigned SUBCYCLES          = 4;

  // Duty waveforms, step 0 in the most significant bit.
  localparam logic [7:0] DUTY_TABLE [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

  // Reset value of one register byte.
  function automatic logic [7:0] reg_reset_value(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      REG_MASTER_VOL: val = RESET_MASTER_VOL;
      REG_PANNING:    val = RESET_PANNING;
      REG_AUDIO_CTRL: val = RESET_AUDIO_CTRL;
      default:        val = 8'h00;
    endcase
    return val;
  endfunction

  // Period countdown reload: four times (2048 - period), 14 bits.
  function automatic logic [13:0] reload_value(input logic [7:0] per_lo,
                                               input logic [2:0] per_hi);
    logic [11:0] diff;
    diff = PERIOD_BASE - {1'b0, per_hi, per_lo};
    return {diff, 2'b00};
  endfunction

  // Level of one duty step.
  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] pos);
    logic [7:0] pat;
    pat = DUTY_TABLE[duty];
    return pat[3'd7 - pos];
  endfunction

endpackage

@@ rtl/pulse_channel_with_register_file_core.sv @@
// Sound register file with pulse channel 2, frame counter and sample decimator.
//
// Usage: each transfer on the input channel (in_valid/in_ready) carries one
// item: a register read (op 0), a register write (op 1) or one machine-cycle
// tick (op 2); op 3 does nothing. Every item yields exactly one transfer on
// the output channel (out_valid/out_ready) with read_data, sample_valid and
// sample_high. Reads return the masked register byte, 0xFF for unmapped
// registers; writes and ticks return zero data. A tick that emits a
// decimated sample raises sample_valid with the level on sample_high.
// Timing: an item is held in an input register and its result is written to
// the output register once that register is free, so each result is
// registered. One item is taken every cycle while the receiver takes results;
// the four sub-cycles of a tick are evaluated in one pass of logic between
// the two registers, where all channel state is also updated.
// When the receiver stalls, the result waits in the output register and one
// more item waits in the input register; in_ready drops only when both are
// full. Reset restores the register bytes (audio controls to 0x77, 0xF3,
// 0xF1), clears the wave store and all channel state, and empties both stages.
module pulse_channel_with_register_file_core
  import pcrf_pkg::*;
#(
  parameter int unsigned WAVE_BYTES = WAVE_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [4:0] reg_index,
  input  logic [3:0] wave_index,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       sample_valid,
  output logic       sample_high
);

  localparam int unsigned WIDX_W = $clog2(WAVE_BYTES);

  // Input stage.
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [4:0] s1_reg_index;
  logic [3:0] s1_wave_index;
  logic [7:0] s1_write_data;
  logic       advance;

  // Storage and channel state.
  logic [7:0]  regs [REG_COUNT];
  logic [7:0]  wave_store [WAVE_BYTES];
  logic        channel_enabled;
  logic [6:0]  length_count;
  logic [13:0] period_count;
  logic [2:0]  duty_position;
  logic        current_level;
  logic [11:0] frame_count;
  logic [6:0]  decimate_count;

  // Next values.
  logic        channel_enabled_next;
  logic [6:0]  length_count_next;
  logic [13:0] period_count_next;
  logic [2:0]  duty_position_next;
  logic        current_level_next;
  logic [11:0] frame_count_next;
  logic [6:0]  decimate_count_next;
  logic [7:0]  read_data_next;
  logic        sample_valid_next;
  logic        sample_high_next;
  logic        reg_we;
  logic        wave_we;

  logic [WIDX_W-1:0] s1_widx;
  logic [7:0]        reg_rd;
  logic [7:0]        wave_rd;
  logic [13:0]       tick_reload;

  // Handshake: the output register frees up when empty or taken.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  assign s1_widx     = WIDX_W'(s1_wave_index);
  assign reg_rd      = regs[s1_reg_index];
  assign wave_rd     = wave_store[s1_widx];
  assign tick_reload = reload_value(regs[REG_CH2_PER_LO], regs[REG_CH2_PER_HI][2:0]);

  // Item evaluation: read-back, register side effects and the tick.
  always_comb begin
    channel_enabled_next = channel_enabled;
    length_count_next    = length_count;
    period_count_next    = period_count;
    duty_position_next   = duty_position;
    current_level_next   = current_level;
    frame_count_next     = frame_count;
    decimate_count_next  = decimate_count;
    read_data_next       = 8'h00;
    sample_valid_next    = 1'b0;
    sample_high_next     = 1'b0;
    reg_we               = 1'b0;
    wave_we              = 1'b0;
    if (advance) begin
      case (s1_op)
        OP_READ: begin
          case (s1_reg_index)
            REG_CH1_DUTY, REG_CH2_DUTY:     read_data_next = reg_rd & READ_MASK_DUTY;
            REG_CH1_PER_LO, REG_CH2_PER_LO: read_data_next = READ_UNMAPPED;
            REG_CH1_PER_HI, REG_CH2_PER_HI: read_data_next = reg_rd & READ_MASK_CTRL;
            REG_WAVE:                       read_data_next = wave_rd;
            default: begin
              read_data_next = (32'(s1_reg_index) < REG_COUNT) ? reg_rd : READ_UNMAPPED;
            end
          endcase
        end
        OP_WRITE: begin
          if (s1_reg_index == REG_WAVE) begin
            wave_we = 1'b1;
          end else if (32'(s1_reg_index) < REG_COUNT) begin
            reg_we = 1'b1;
            if (s1_reg_index == REG_CH2_DUTY) begin
              length_count_next = LENGTH_MAX - (s1_write_data[6:0] & LENGTH_FIELD[6:0]);
            end else if (s1_reg_index == REG_CH2_PER_HI &&
                         (s1_write_data & TRIGGER_BIT) != 8'h00) begin
              channel_enabled_next = 1'b1;
              period_count_next    = reload_value(regs[REG_CH2_PER_LO], s1_write_data[2:0]);
              if (length_count == 7'd0) begin
                length_count_next = LENGTH_MAX;
              end
            end
          end
        end
        OP_TICK: begin
          frame_count_next = frame_count + 12'd1;
          if (channel_enabled && length_count != 7'd0) begin
            if (frame_count_next == 12'd0) begin
              length_count_next = length_count - 7'd1;
              if (length_count_next == 7'd0) begin
                channel_enabled_next = 1'b0;
                current_level_next   = 1'b0;
              end
            end
            for (int k = 0; k < SUBCYCLES; k++) begin
              period_count_next = period_count_next - 14'd1;
              if (period_count_next == 14'd0) begin
                period_count_next  = tick_reload;
                current_level_next = duty_bit(regs[REG_CH2_DUTY][7:6], duty_position_next);
                duty_position_next = duty_position_next + 3'd1;
              end
              decimate_count_next = decimate_count_next + 7'd1;
              if (decimate_count_next == DECIMATION) begin
                decimate_count_next = 7'd0;
                sample_valid_next   = 1'b1;
                sample_high_next    = current_level_next;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_op         <= op;
      s1_reg_index  <= reg_index;
      s1_wave_index <= wave_index;
      s1_write_data <= write_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      read_data    <= read_data_next;
      sample_valid <= sample_valid_next;
      sample_high  <= sample_high_next;
    end
  end

  // Register file and wave store.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= reg_reset_value(5'(i));
      end
      for (int j = 0; j < WAVE_BYTES; j++) begin
        wave_store[j] <= 8'h00;
      end
    end else begin
      if (reg_we) begin
        regs[s1_reg_index] <= s1_write_data;
      end
      if (wave_we) begin
        wave_store[s1_widx] <= s1_write_data;
      end
    end
  end

  // Channel state.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enabled <= 1'b0;
      length_count    <= 7'd0;
      period_count    <= 14'd0;
      duty_position   <= 3'd0;
      current_level   <= 1'b0;
      frame_count     <= 12'd0;
      decimate_count  <= 7'd0;
    end else begin
      channel_enabled <= channel_enabled_next;
      length_count    <= length_count_next;
      period_count    <= period_count_next;
      duty_position   <= duty_position_next;
      current_level   <= current_level_next;
      frame_count     <= frame_count_next;
      decimate_count  <= decimate_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The decimator clears before it reaches its terminal count.
  a_decimate_range: assert property (@(posedge clk) disable iff (rst)
    decimate_count < DECIMATION)
    else $error("decimator count out of range");

  // The length counter never exceeds its full value.
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    length_count <= LENGTH_MAX)
    else $error("length counter out of range");

  // Input stalls only when both stages hold an item and the output is stalled.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  // A result carries either read data or a sample, never both.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_valid) |-> (read_data == 8'h00))
    else $error("sample and read data in one result");
`endif

endmodule
